// ===== rtl/core/tfd_pkg.sv =====
// shared types and constants for the thermal frame deframer
package tfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned VAL_W    = 14;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned PIX_W    = 6;
    localparam int unsigned RUN_W    = 2;
    localparam int unsigned FRAME_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 14;

    localparam logic [BYTE_W-1:0]  HDR_BYTE     = 8'h2A;
    localparam logic [RUN_W-1:0]   HDR_RUN_LAST = 2'd2;
    localparam logic [POS_W-1:0]   SKIP_BYTES   = 8'd2;
    localparam logic [POS_W-1:0]   LAST_POS     = 8'd129;

    localparam logic [VAL_W-1:0]   CLAMP_MIN_RST = 14'd15;
    localparam logic [VAL_W-1:0]   CLAMP_MAX_RST = 14'd40;

    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_MAX = 2'd1;

    typedef struct packed {
        logic               emit;
        logic [WORD_W-1:0]  word;
        logic [PIX_W-1:0]   pix;
        logic               last;
        logic [FRAME_W-1:0] frame_num;
    } t_pix_info;

endpackage

// ===== rtl/core/tfd_parse.sv =====
// header hunt, byte pairing and frame counting
module tfd_parse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [tfd_pkg::BYTE_W-1:0] i_byte,
    output tfd_pkg::t_pix_info        o_info
);
    import tfd_pkg::*;

    logic [RUN_W-1:0]   r_star_run, n_star_run;
    logic               r_in_packet, n_in_packet;
    logic [POS_W-1:0]   r_byte_position, n_byte_position;
    logic [BYTE_W-1:0]  r_held_low, n_held_low;
    logic [FRAME_W-1:0] r_frame_count, n_frame_count;
    logic [POS_W-1:0]   pos_m2;

    assign pos_m2 = r_byte_position - SKIP_BYTES;

    always_comb begin
        n_star_run      = r_star_run;
        n_in_packet     = r_in_packet;
        n_byte_position = r_byte_position;
        n_held_low      = r_held_low;
        n_frame_count   = r_frame_count;
        o_info.emit      = 1'b0;
        o_info.word      = {i_byte, r_held_low};
        o_info.pix       = pos_m2[PIX_W:1];
        o_info.last      = (r_byte_position == LAST_POS);
        o_info.frame_num = r_frame_count + FRAME_W'(1);
        if (!r_in_packet) begin
            if (i_byte == HDR_BYTE) begin
                if (r_star_run == HDR_RUN_LAST) begin
                    n_star_run      = '0;
                    n_in_packet     = 1'b1;
                    n_byte_position = '0;
                end else begin
                    n_star_run = r_star_run + RUN_W'(1);
                end
            end else begin
                n_star_run = '0;
            end
        end else begin
            n_byte_position = r_byte_position + POS_W'(1);
            if (r_byte_position >= SKIP_BYTES) begin
                // pairs start on an even position, low byte first
                if (!r_byte_position[0]) begin
                    n_held_low = i_byte;
                end else begin
                    o_info.emit = 1'b1;
                    if (o_info.last) begin
                        n_frame_count   = o_info.frame_num;
                        n_in_packet     = 1'b0;
                        n_star_run      = '0;
                        n_byte_position = '0;
                        n_held_low      = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star_run      <= '0;
            r_in_packet     <= 1'b0;
            r_byte_position <= '0;
            r_held_low      <= '0;
            r_frame_count   <= '0;
        end else if (i_step) begin
            r_star_run      <= n_star_run;
            r_in_packet     <= n_in_packet;
            r_byte_position <= n_byte_position;
            r_held_low      <= n_held_low;
            r_frame_count   <= n_frame_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_zero_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_packet |-> r_byte_position == '0)
        else $error("byte position not zero while hunting");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_position <= LAST_POS)
        else $error("byte position beyond end of packet");
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_info.emit && o_info.last) |=> !r_in_packet)
        else $error("still in packet after last pixel");
`endif

endmodule

// ===== rtl/core/tfd_scale.sv =====
// divide by four and clamp to the configured bounds
module tfd_scale (
    input  logic [tfd_pkg::WORD_W-1:0] i_word,
    input  logic [tfd_pkg::VAL_W-1:0]  i_clamp_min,
    input  logic [tfd_pkg::VAL_W-1:0]  i_clamp_max,
    output logic [tfd_pkg::VAL_W-1:0]  o_value
);
    import tfd_pkg::*;

    logic [VAL_W-1:0] scaled;
    logic [VAL_W-1:0] raised;

    assign scaled  = i_word[WORD_W-1:2];
    // lower bound first, then the upper one wins
    assign raised  = (scaled < i_clamp_min) ? i_clamp_min : scaled;
    assign o_value = (raised > i_clamp_max) ? i_clamp_max : raised;

endmodule

// ===== rtl/core/thermal_frame_deframer_core.sv =====
// Thermal frame deframer top level: input register, parser, scaler, result register.
// A high byte is held in the input register, its pixel then in the result register.
// One byte per cycle unless stalled; set by the input and result register pair.
// Stall on the result side holds the result register and then the input register.
// Reset (synchronous, active low) returns to header hunt, clears frame count,
// empties both registers and sets the clamp bounds to 15 and 40.
module thermal_frame_deframer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tfd_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tfd_pkg::VAL_W-1:0]       o_pixel_value,
    output logic [2:0]                      o_pixel_row,
    output logic [2:0]                      o_pixel_col,
    output logic [tfd_pkg::FRAME_W-1:0]     o_frame_index,
    output logic                            o_frame_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tfd_pkg::*;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_pixel_value;
    logic [PIX_W-1:0]   r_pix;
    logic [FRAME_W-1:0] r_frame_index;
    logic               r_frame_end;
    logic [VAL_W-1:0]   r_clamp_min;
    logic [VAL_W-1:0]   r_clamp_max;

    logic               advance;
    logic               step;
    t_pix_info          info;
    logic [VAL_W-1:0]   value;

    assign advance     = !r_out_valid || !i_stall;
    assign step        = r_in_valid && advance;
    assign o_stall     = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    tfd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_info  (info)
    );

    tfd_scale u_scale (
        .i_word      (info.word),
        .i_clamp_min (r_clamp_min),
        .i_clamp_max (r_clamp_max),
        .o_value     (value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_min <= CLAMP_MIN_RST;
            r_clamp_max <= CLAMP_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLAMP_MIN: r_clamp_min <= i_cfg_data;
                CFG_CLAMP_MAX: r_clamp_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || advance) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && info.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && info.emit) begin
            r_pixel_value <= value;
            r_pix         <= info.pix;
            r_frame_index <= info.frame_num;
            r_frame_end   <= info.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_pixel_value;
    assign o_pixel_row   = r_pix[5:3];
    assign o_pixel_col   = r_pix[2:0];
    assign o_frame_index = r_frame_index;
    assign o_frame_end   = r_frame_end;

`ifndef NO_ASSERTIONS
    a_end_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> (o_pixel_row == 3'd7 && o_pixel_col == 3'd7))
        else $error("frame end flagged away from last pixel");
    a_under_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel_value <= r_clamp_max)
        else $error("pixel above upper clamp bound");
    a_over_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_clamp_min <= r_clamp_max) |-> o_pixel_value >= r_clamp_min)
        else $error("pixel below lower clamp bound");
`endif

endmodule

// ===== dv/tfd_pixel_checker.sv =====
// pixel predictor and scoreboard for the thermal frame deframer testbench
module tfd_pixel_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_byte_valid,
    input  logic                            i_byte_stall,
    input  logic [tfd_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic                            i_pix_valid,
    input  logic                            i_pix_stall,
    input  logic [tfd_pkg::VAL_W-1:0]       i_pixel_value,
    input  logic [2:0]                      i_pixel_row,
    input  logic [2:0]                      i_pixel_col,
    input  logic [tfd_pkg::FRAME_W-1:0]     i_frame_index,
    input  logic                            i_frame_end,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import tfd_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } t_pixel;

    t_pixel             pixel_q[$];
    int                 fails = 0;

    logic [RUN_W-1:0]   star_run;
    logic               in_packet;
    logic [POS_W-1:0]   byte_pos;
    logic [BYTE_W-1:0]  held_lo;
    logic [FRAME_W-1:0] frames_done;
    logic [VAL_W-1:0]   lo_bound;
    logic [VAL_W-1:0]   hi_bound;

    // lower bound first, so crossed bounds collapse onto the upper one
    function automatic logic [VAL_W-1:0] scale_to_degrees(input logic [WORD_W-1:0] word);
        logic [VAL_W-1:0] t;
        t = word[WORD_W-1:2];
        if (t < lo_bound) t = lo_bound;
        if (t > hi_bound) t = hi_bound;
        return t;
    endfunction

    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] data_pos;
        logic [PIX_W-1:0] pix;
        t_pixel           px;
        if (!in_packet) begin
            if (b == HDR_BYTE) begin
                if (star_run >= HDR_RUN_LAST) begin
                    star_run  = '0;
                    in_packet = 1'b1;
                    byte_pos  = '0;
                end else begin
                    star_run = star_run + RUN_W'(1);
                end
            end else begin
                star_run = '0;
            end
        end else begin
            pos      = byte_pos;
            byte_pos = pos + POS_W'(1);
            if (pos >= SKIP_BYTES) begin
                data_pos = pos - SKIP_BYTES;
                if (!data_pos[0]) begin
                    held_lo = b;
                end else begin
                    pix      = data_pos[PIX_W:1];
                    px.value = scale_to_degrees({b, held_lo});
                    px.row   = pix[5:3];
                    px.col   = pix[2:0];
                    px.frame = frames_done + FRAME_W'(1);
                    px.last  = (pix == {PIX_W{1'b1}});
                    pixel_q.push_back(px);
                    if (px.last) begin
                        frames_done = px.frame;
                        in_packet   = 1'b0;
                        star_run    = '0;
                        byte_pos    = '0;
                        held_lo     = '0;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (!i_rst_n) begin
            pixel_q.delete();
            star_run    = '0;
            in_packet   = 1'b0;
            byte_pos    = '0;
            held_lo     = '0;
            frames_done = '0;
            lo_bound    = CLAMP_MIN_RST;
            hi_bound    = CLAMP_MAX_RST;
        end else begin
            if (i_pix_valid && !i_pix_stall) begin
                got.value = i_pixel_value;
                got.row   = i_pixel_row;
                got.col   = i_pixel_col;
                got.frame = i_frame_index;
                got.last  = i_frame_end;
                if (pixel_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected pixel value %0d row %0d col %0d",
                             $time, got.value, got.row, got.col,
                             " frame %0d end %0d", got.frame, got.last);
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        $display("%0t: pixel mismatch, expected value %0d row %0d col %0d",
                                 $time, want.value, want.row, want.col,
                                 " frame %0d end %0d", want.frame, want.last);
                        $display("%0t:                 actual   value %0d row %0d col %0d",
                                 $time, got.value, got.row, got.col,
                                 " frame %0d end %0d", got.frame, got.last);
                    end
                end
            end
            if (i_byte_valid && !i_byte_stall) begin
                absorb_byte(i_rx_byte);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CLAMP_MIN: lo_bound = i_cfg_data;
                    CFG_CLAMP_MAX: hi_bound = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= pixel_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: byte stimulus, clamp settings, flow control and verdict
module tb_top;
    import tfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [BYTE_W-1:0]      i_rx_byte = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [VAL_W-1:0]       o_pixel_value;
    logic [2:0]             o_pixel_row;
    logic [2:0]             o_pixel_col;
    logic [FRAME_W-1:0]     o_frame_index;
    logic                   o_frame_end;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    int                     fail_count;
    int                     pixels_pending;
    int unsigned            cycle_cnt = 0;
    int unsigned            tx_idle_pct = 31;
    int unsigned            rx_idle_pct = 77;
    logic                   long_hold_req = 1'b0;
    logic                   long_hold_done = 1'b0;
    int unsigned            hold_left = 0;

    thermal_frame_deframer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_value  (o_pixel_value),
        .o_pixel_row    (o_pixel_row),
        .o_pixel_col    (o_pixel_col),
        .o_frame_index  (o_frame_index),
        .o_frame_end    (o_frame_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tfd_pixel_checker u_pixel_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (i_valid),
        .i_byte_stall   (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_pix_valid    (o_valid),
        .i_pix_stall    (i_stall),
        .i_pixel_value  (o_pixel_value),
        .i_pixel_row    (o_pixel_row),
        .i_pixel_col    (o_pixel_col),
        .i_frame_index  (o_frame_index),
        .i_frame_end    (o_frame_end),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pixels_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("thermal_frame_deframer_core regression: fail");
            $finish;
        end
    end

    // pixel receiver: random stall, plus one long hold so the pipeline backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall        <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            i_stall        <= 1'b1;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // drain every outstanding pixel, then let the pipeline settle
    task automatic drain_pixels();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_bounds(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
        write_reg(CFG_CLAMP_MIN, lo);
        write_reg(CFG_CLAMP_MAX, hi);
    endtask

    // noise with broken star runs, a header, thermistor bytes and 64 pixel words
    task automatic send_frame_burst();
        int unsigned n_noise;
        n_noise = $urandom_range(1, 8);
        repeat (n_noise) begin
            if ($urandom_range(0, 9) < 4) send_byte(HDR_BYTE);
            else send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        repeat (3) send_byte(HDR_BYTE);
        repeat (LAST_POS + 1) begin
            if ($urandom_range(0, 15) == 0) send_byte(HDR_BYTE);
            else send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // broken headers, then a real one
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(8'h00);
        send_byte(HDR_BYTE);
        send_byte(8'h41);
        repeat (3) send_byte(HDR_BYTE);
        // thermistor bytes
        send_byte(8'hFF);
        send_byte(HDR_BYTE);
        // word extremes, stars as data, values on and inside the bounds
        send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'hFF);
        send_byte(HDR_BYTE); send_byte(HDR_BYTE);
        send_byte(8'hA0); send_byte(8'h00);
        send_byte(8'h3C); send_byte(8'h00);
        send_byte(8'h7F); send_byte(8'h00);
        send_byte(8'h55); send_byte(8'hAA);
        send_byte(8'hAA); send_byte(8'h55);

        drain_pixels();
        write_bounds('0, VAL_MAX);
        send_frame_burst();

        drain_pixels();
        // crossed bounds
        write_bounds(VAL_MAX, '0);
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(0, VAL_MAX)));
        send_frame_burst();

        tx_idle_pct = 77;
        rx_idle_pct = 31;
        drain_pixels();
        lo = VAL_W'($urandom_range(0, 4095));
        hi = VAL_W'($urandom_range(lo, VAL_MAX));
        write_bounds(lo, hi);
        send_frame_burst();

        drain_pixels();
        lo = VAL_W'($urandom_range(0, VAL_MAX));
        write_bounds(lo, lo);
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(0, VAL_MAX)));
        send_frame_burst();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_pixels();
        write_bounds(VAL_W'($urandom_range(0, VAL_MAX)), VAL_W'($urandom_range(0, VAL_MAX)));
        long_hold_req <= 1'b1;
        send_frame_burst();

        drain_pixels();
        if (fail_count == 0 && pixels_pending == 0) begin
            $display("thermal_frame_deframer_core regression: pass");
        end else begin
            $display("thermal_frame_deframer_core regression: fail");
        end
        $finish;
    end

endmodule
